/* hw/rtl/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked property wrappers used by the checker module of this project.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PITE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: overlapping implication");

// The consequent must hold in the cycle after the antecedent.
`define PITE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/pite_pkg.sv */
// -----------------------------------------------------------------------------
// Process table engine package
// Widths, codes, payload types and the reset image of the process table.
// -----------------------------------------------------------------------------
package pite_pkg;

  // The table is indexed by the low bits of the process id.
  localparam int SLOT_W     = 6;
  localparam int SLOTS      = 2 ** SLOT_W;
  localparam int LIVE_W     = SLOT_W + 1;
  localparam int PAGE_BYTES = 4096;

  localparam int PID_W       = 32;
  localparam int MEM_W       = 15;
  localparam int STACK_W     = 47;
  localparam int STACK_SHIFT = $clog2(PAGE_BYTES * 8);
  localparam int ACT_W       = 7;

  localparam logic [STACK_W-1:0] STACK_CEIL = 47'h7FFF_0000_0000;
  localparam logic [MEM_W-1:0]   INIT_MEM   = MEM_W'(PAGE_BYTES * 4);
  localparam logic [PID_W-1:0]   NO_PID     = '1;
  localparam logic [7:0]         PRIO_IDLE  = 8'd255;

  // Process states; codes above terminated are stored as given.
  localparam logic [2:0] PS_READY   = 3'd1;
  localparam logic [2:0] PS_RUNNING = 3'd2;
  localparam logic [2:0] PS_TERM    = 3'd4;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_KILL      = 3'd1,
    OP_SET_STATE = 3'd2,
    OP_SET_PRIO  = 3'd3,
    OP_INFO      = 3'd4,
    OP_FORK      = 3'd5,
    OP_COUNT     = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DENIED    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [PID_W-1:0] target_pid;
    logic [7:0]       priority_in;
    logic             kernel_in;
    logic [2:0]       state_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PID_W-1:0]   pid_out;
    logic [2:0]         proc_state;
    logic [7:0]         priority_out;
    logic               kernel_out;
    logic [PID_W-1:0]   parent_out;
    logic [MEM_W-1:0]   mem_bytes;
    logic [STACK_W-1:0] stack_top;
    logic [ACT_W-1:0]   active_count;
  } rsp_t;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [2:0]       pstate;
    logic [7:0]       prio;
    logic             kernel;
    logic [PID_W-1:0] parent;
    logic [MEM_W-1:0] mem;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Contents of a slot that has not been written since reset.
  function automatic entry_t reset_entry(logic [SLOT_W-1:0] slot);
    entry_t e;
    e.pid    = NO_PID;
    e.pstate = PS_TERM;
    e.prio   = '0;
    e.kernel = 1'b0;
    e.parent = '0;
    e.mem    = '0;
    if (slot == SLOT_W'(0)) begin
      e.pid    = '0;
      e.pstate = PS_RUNNING;
      e.prio   = PRIO_IDLE;
      e.kernel = 1'b1;
    end else if (slot == SLOT_W'(1)) begin
      e.pid    = PID_W'(1);
      e.pstate = PS_READY;
      e.kernel = 1'b1;
      e.parent = PID_W'(1);
      e.mem    = INIT_MEM;
    end
    return e;
  endfunction

endpackage

/* hw/rtl/pite_ifs.sv */
// -----------------------------------------------------------------------------
// Process table engine channels
// Valid/ready channels for requests and results.
// -----------------------------------------------------------------------------
interface pite_req_if;
  logic            valid;
  logic            ready;
  pite_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pite_rsp_if;
  logic            valid;
  logic            ready;
  pite_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/pite_ram.sv */
// -----------------------------------------------------------------------------
// Table memory
// Single write port, single read port, read data registered.
// -----------------------------------------------------------------------------
module pite_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/process_id_table_engine_core.sv */
// -----------------------------------------------------------------------------
// Process table engine
// Process table with a recycling process-id allocator, one operation at a time.
// -----------------------------------------------------------------------------
// The table lives in one single-port-read memory of SLOTS entries addressed by
// the low bits of the process id; a per-slot written flag stands in for the
// reset image, so the block is usable straight after reset with no clearing
// pass. One request is in flight at a time. Count, an undefined opcode, a refused
// kill and a create on a full table go from transfer straight to the result
// state; kill, set state, set priority and info first read the target's slot.
// Create scans slots from the next free id, and fork reads the parent and then
// scans likewise; each examined slot costs one memory read and an inspection
// of its data. A finished result sits in the output register, so the next
// request is taken while it waits.
module process_id_table_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pite_req_if.sink    in_i,
  pite_rsp_if.source  out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam int SW = pite_pkg::SLOT_W;
  localparam int LW = pite_pkg::LIVE_W;

  logic [2:0] state_q, state_d;
  pite_pkg::req_t req_q, req_d;
  logic [LW-1:0] live_q, live_d;
  logic [pite_pkg::PID_W-1:0] next_pid_q, next_pid_d;
  logic [pite_pkg::PID_W-1:0] cand_q, cand_d;
  logic [SW-1:0] cnt_q, cnt_d;
  pite_pkg::entry_t par_q, par_d;
  pite_pkg::entry_t res_q, res_d;
  logic [1:0] res_status_q, res_status_d;
  logic res_has_q, res_has_d;
  pite_pkg::rsp_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [pite_pkg::SLOTS-1:0] written_q;
  logic rd_written_q;
  logic [SW-1:0] rd_slot_q;

  logic re;
  logic [SW-1:0] raddr;
  logic we;
  logic [SW-1:0] waddr;
  pite_pkg::entry_t wdata;
  logic [pite_pkg::ENTRY_W-1:0] ram_rdata;
  pite_pkg::entry_t rd_ent;
  pite_pkg::entry_t mod_ent;
  pite_pkg::entry_t new_ent;
  pite_pkg::rsp_t rsp_build;
  logic live_full;
  logic found;
  logic slot_free;
  logic is_fork;

  pite_ram #(
    .DEPTH (pite_pkg::SLOTS),
    .WIDTH (pite_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // Slots never written since reset read as their reset image.
  assign rd_ent = rd_written_q ? pite_pkg::entry_t'(ram_rdata)
                               : pite_pkg::reset_entry(rd_slot_q);

  assign live_full = live_q >= LW'(pite_pkg::SLOTS - 1);
  assign found     = (rd_ent.pid == req_q.target_pid) && (rd_ent.pstate != pite_pkg::PS_TERM);
  assign slot_free = (rd_ent.pstate == pite_pkg::PS_TERM) || (rd_ent.pid == pite_pkg::NO_PID);
  assign is_fork   = pite_pkg::op_e'(req_q.opcode) == pite_pkg::OP_FORK;

  always_comb begin
    new_ent.pid    = cand_q;
    new_ent.pstate = pite_pkg::PS_READY;
    new_ent.prio   = is_fork ? par_q.prio : req_q.priority_in;
    new_ent.kernel = is_fork ? par_q.kernel : req_q.kernel_in;
    new_ent.parent = is_fork ? req_q.target_pid : pite_pkg::PID_W'(1);
    new_ent.mem    = is_fork ? par_q.mem : pite_pkg::INIT_MEM;
  end

  always_comb begin
    mod_ent = rd_ent;
    unique case (pite_pkg::op_e'(req_q.opcode))
      pite_pkg::OP_KILL:      mod_ent.pstate = pite_pkg::PS_TERM;
      pite_pkg::OP_SET_STATE: mod_ent.pstate = req_q.state_in;
      pite_pkg::OP_SET_PRIO:  mod_ent.prio   = req_q.priority_in;
      default: ;
    endcase
  end

  // Result word; the stack base subtract sits between two registers.
  always_comb begin
    rsp_build.status       = res_status_q;
    rsp_build.active_count = pite_pkg::ACT_W'(live_q);
    if (res_has_q) begin
      rsp_build.pid_out      = res_q.pid;
      rsp_build.proc_state   = res_q.pstate;
      rsp_build.priority_out = res_q.prio;
      rsp_build.kernel_out   = res_q.kernel;
      rsp_build.parent_out   = res_q.parent;
      rsp_build.mem_bytes    = res_q.mem;
      rsp_build.stack_top    = pite_pkg::STACK_CEIL -
        pite_pkg::STACK_W'({res_q.pid, {pite_pkg::STACK_SHIFT{1'b0}}});
    end else begin
      rsp_build.pid_out      = (res_status_q == pite_pkg::ST_OK) ? '0 : pite_pkg::NO_PID;
      rsp_build.proc_state   = '0;
      rsp_build.priority_out = '0;
      rsp_build.kernel_out   = 1'b0;
      rsp_build.parent_out   = '0;
      rsp_build.mem_bytes    = '0;
      rsp_build.stack_top    = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    live_d       = live_q;
    next_pid_d   = next_pid_q;
    cand_d       = cand_q;
    cnt_d        = cnt_q;
    par_d        = par_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    res_has_d    = res_has_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    re           = 1'b0;
    raddr        = in_i.data.target_pid[SW-1:0];
    we           = 1'b0;
    waddr        = rd_slot_q;
    wdata        = mod_ent;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          req_d = in_i.data;
          unique case (pite_pkg::op_e'(in_i.data.opcode))
            pite_pkg::OP_CREATE: begin
              if (live_full) begin
                res_status_d = pite_pkg::ST_FULL;
                res_has_d    = 1'b0;
                state_d      = S_RESP;
              end else begin
                cand_d  = next_pid_q;
                cnt_d   = '0;
                state_d = S_SCAN;
              end
            end
            pite_pkg::OP_KILL: begin
              if (in_i.data.target_pid == '0) begin
                res_status_d = pite_pkg::ST_DENIED;
                res_has_d    = 1'b0;
                state_d      = S_RESP;
              end else begin
                re      = 1'b1;
                state_d = S_LOOK;
              end
            end
            pite_pkg::OP_SET_STATE, pite_pkg::OP_SET_PRIO,
            pite_pkg::OP_INFO, pite_pkg::OP_FORK: begin
              re      = 1'b1;
              state_d = S_LOOK;
            end
            default: begin
              res_status_d = pite_pkg::ST_OK;
              res_has_d    = 1'b0;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      S_LOOK: begin
        res_status_d = pite_pkg::ST_OK;
        res_has_d    = 1'b1;
        res_d        = mod_ent;
        state_d      = S_RESP;
        if (!found) begin
          res_status_d = pite_pkg::ST_NOT_FOUND;
          res_has_d    = 1'b0;
        end else begin
          unique case (pite_pkg::op_e'(req_q.opcode))
            pite_pkg::OP_KILL: begin
              we = 1'b1;
              if (live_q != '0) begin
                live_d = live_q - LW'(1);
              end
            end
            pite_pkg::OP_SET_STATE, pite_pkg::OP_SET_PRIO: we = 1'b1;
            pite_pkg::OP_FORK: begin
              par_d = rd_ent;
              if (live_full) begin
                res_status_d = pite_pkg::ST_FULL;
                res_has_d    = 1'b0;
              end else begin
                cand_d  = next_pid_q;
                cnt_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        re      = 1'b1;
        raddr   = cand_q[SW-1:0];
        state_d = S_CHECK;
      end

      S_CHECK: begin
        if (slot_free) begin
          next_pid_d = cand_q + pite_pkg::PID_W'(1);
          state_d    = S_RESP;
          if (cand_q == pite_pkg::NO_PID) begin
            // The all-ones id is never handed out, but the counter still moves on.
            res_status_d = pite_pkg::ST_FULL;
            res_has_d    = 1'b0;
          end else begin
            we           = 1'b1;
            wdata        = new_ent;
            live_d       = live_q + LW'(1);
            res_d        = new_ent;
            res_status_d = pite_pkg::ST_OK;
            res_has_d    = 1'b1;
          end
        end else if (cnt_q == '1) begin
          res_status_d = pite_pkg::ST_FULL;
          res_has_d    = 1'b0;
          state_d      = S_RESP;
        end else begin
          cand_d  = cand_q + pite_pkg::PID_W'(1);
          cnt_d   = cnt_q + SW'(1);
          state_d = S_SCAN;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = rsp_build;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= LW'(1);
      next_pid_q  <= pite_pkg::PID_W'(2);
      out_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      next_pid_q  <= next_pid_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        written_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    cand_q       <= cand_d;
    cnt_q        <= cnt_d;
    par_q        <= par_d;
    res_q        <= res_d;
    res_status_q <= res_status_d;
    res_has_q    <= res_has_d;
    out_q        <= out_d;
    if (re) begin
      rd_slot_q    <= raddr;
      rd_written_q <= written_q[raddr];
    end
  end

  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

/* hw/rtl/pite_checker.sv */
// -----------------------------------------------------------------------------
// Process table engine checker
// Port-level properties of the engine, attached to the top level by bind.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pite_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [1:0]                           out_status_i,
  input logic [pite_pkg::PID_W-1:0]           out_pid_i,
  input logic [pite_pkg::STACK_W-1:0]         out_stack_i
);

  // A waiting result is not withdrawn.
  `PITE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Only one request is worked on at a time.
  `PITE_ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A new result only shows up after the engine has been busy.
  `PITE_ASSERT_IMPL(a_rsp_after_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

  // Failed operations carry the no-process id and no stack base.
  `PITE_ASSERT_IMPL(a_fail_fields, clk_i, rst_ni, out_valid_i && (out_status_i != pite_pkg::ST_OK), (out_pid_i == pite_pkg::NO_PID) && (out_stack_i == '0))

endmodule

bind process_id_table_engine_core pite_checker u_pite_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.data.status),
  .out_pid_i    (out_o.data.pid_out),
  .out_stack_i  (out_o.data.stack_top)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Process table engine testbench
// Drives process-table requests through a table of directed cases and then
// random sequences under several idling patterns. Every result is compared
// field by field with a typed expectation or a predictor with its own table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pite_pkg::*;

  localparam logic [2:0] OP_UNDEF    = 3'd7;
  localparam logic [2:0] PS_CREATED  = 3'd0;
  localparam logic [2:0] PS_BLOCKED  = 3'd3;
  localparam logic [2:0] PS_SPARE    = 3'd7;
  localparam int         RAND_ITEMS  = 136;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TAIL_CYCLES = 2 * SLOTS + 8;
  localparam int         CYCLE_LIMIT = 400000;

  typedef enum int {
    MODE_STEADY,
    MODE_SRC_IDLE,
    MODE_SNK_STALL,
    MODE_BOTH,
    MODE_PRESSURE
  } mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pite_req_if req_if ();
  pite_rsp_if rsp_if ();

  process_id_table_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Predictor copy of the process table.
  entry_t           proc_tbl [SLOTS];
  int unsigned      live_procs;
  logic [PID_W-1:0] next_free_pid;

  rsp_t  pending_results [$];
  req_t  dir_req [$];
  bit    dir_typed [$];
  rsp_t  dir_rsp [$];
  mode_e mode = MODE_STEADY;

  int unsigned n_sent, n_checked, n_err;
  int unsigned n_ok, n_missing, n_denied, n_full;

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      proc_tbl[i] = '{pid: NO_PID, pstate: PS_TERM, prio: 8'd0, kernel: 1'b0,
                      parent: '0, mem: '0};
    end
    proc_tbl[0] = '{pid: '0, pstate: PS_RUNNING, prio: 8'd255, kernel: 1'b1,
                    parent: '0, mem: '0};
    proc_tbl[1] = '{pid: PID_W'(1), pstate: PS_READY, prio: 8'd0, kernel: 1'b1,
                    parent: PID_W'(1), mem: MEM_W'(PAGE_BYTES * 4)};
    live_procs = 1;
    next_free_pid = PID_W'(2);
  endfunction

  function automatic int find_live(logic [PID_W-1:0] pid);
    logic [SLOT_W-1:0] s;
    s = pid[SLOT_W-1:0];
    if (proc_tbl[s].pid == pid && proc_tbl[s].pstate != PS_TERM) return int'(s);
    return -1;
  endfunction

  function automatic rsp_t entry_view(int s);
    rsp_t v;
    v = '0;
    v.status       = ST_OK;
    v.pid_out      = proc_tbl[s].pid;
    v.proc_state   = proc_tbl[s].pstate;
    v.priority_out = proc_tbl[s].prio;
    v.kernel_out   = proc_tbl[s].kernel;
    v.parent_out   = proc_tbl[s].parent;
    v.mem_bytes    = proc_tbl[s].mem;
    v.stack_top    = 47'h7FFF_0000_0000 - (STACK_W'(proc_tbl[s].pid) << 15);
    return v;
  endfunction

  function automatic rsp_t refusal(status_e code);
    rsp_t v;
    v = '0;
    v.status  = code;
    v.pid_out = NO_PID;
    return v;
  endfunction

  // Scans forward from the next free id; returns the new slot or -1.
  function automatic int allocate_pid(logic [7:0] prio, logic kern);
    logic [PID_W-1:0]  cand;
    logic [SLOT_W-1:0] s;
    bit                hit;
    if (live_procs >= SLOTS - 1) return -1;
    cand = next_free_pid;
    hit = 1'b0;
    for (int i = 0; i < SLOTS && !hit; i++) begin
      s = cand[SLOT_W-1:0];
      if (proc_tbl[s].pstate == PS_TERM || proc_tbl[s].pid == NO_PID) hit = 1'b1;
      else cand = cand + PID_W'(1);
    end
    if (!hit) return -1;
    next_free_pid = cand + PID_W'(1);
    if (cand == NO_PID) return -1;
    s = cand[SLOT_W-1:0];
    proc_tbl[s] = '{pid: cand, pstate: PS_READY, prio: prio, kernel: kern,
                    parent: PID_W'(1), mem: MEM_W'(PAGE_BYTES * 4)};
    live_procs++;
    return int'(s);
  endfunction

  function automatic rsp_t process_table_outcome(req_t r);
    rsp_t res;
    int   s;
    int   c;
    res = '0;
    case (r.opcode)
      OP_CREATE: begin
        c = allocate_pid(r.priority_in, r.kernel_in);
        res = (c < 0) ? refusal(ST_FULL) : entry_view(c);
      end
      OP_KILL: begin
        s = find_live(r.target_pid);
        if (r.target_pid == '0) res = refusal(ST_DENIED);
        else if (s < 0) res = refusal(ST_NOT_FOUND);
        else begin
          proc_tbl[s].pstate = PS_TERM;
          if (live_procs > 0) live_procs--;
          res = entry_view(s);
        end
      end
      OP_SET_STATE, OP_SET_PRIO, OP_INFO: begin
        s = find_live(r.target_pid);
        if (s < 0) res = refusal(ST_NOT_FOUND);
        else begin
          if (r.opcode == OP_SET_STATE) proc_tbl[s].pstate = r.state_in;
          else if (r.opcode == OP_SET_PRIO) proc_tbl[s].prio = r.priority_in;
          res = entry_view(s);
        end
      end
      OP_FORK: begin
        s = find_live(r.target_pid);
        if (s < 0) res = refusal(ST_NOT_FOUND);
        else begin
          c = allocate_pid(proc_tbl[s].prio, proc_tbl[s].kernel);
          if (c < 0) res = refusal(ST_FULL);
          else begin
            proc_tbl[c].parent = r.target_pid;
            proc_tbl[c].mem = proc_tbl[s].mem;
            res = entry_view(c);
          end
        end
      end
      default: res = '0;
    endcase
    res.active_count = ACT_W'(live_procs);
    return res;
  endfunction

  function automatic req_t rq(logic [2:0] op, logic [PID_W-1:0] pid, logic [7:0] prio,
                              logic kern, logic [2:0] st);
    req_t r;
    r.opcode      = op;
    r.target_pid  = pid;
    r.priority_in = prio;
    r.kernel_in   = kern;
    r.state_in    = st;
    return r;
  endfunction

  function automatic void add_step(req_t r, bit typed, rsp_t want);
    dir_req.push_back(r);
    dir_typed.push_back(typed);
    dir_rsp.push_back(want);
  endfunction

  // Random request; most targets are taken from live processes so that the
  // lookups succeed and the table fills and recycles.
  function automatic req_t random_request(int unsigned create_pct);
    req_t              r;
    int unsigned       roll;
    logic [SLOT_W-1:0] s;
    bit                got;
    r.priority_in = 8'($urandom_range(255));
    r.kernel_in   = 1'($urandom_range(1));
    r.state_in    = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(4));
    roll = $urandom_range(99);
    if (roll < create_pct) r.opcode = OP_CREATE;
    else begin
      roll = $urandom_range(99);
      if (roll < 22)      r.opcode = OP_KILL;
      else if (roll < 38) r.opcode = OP_SET_STATE;
      else if (roll < 53) r.opcode = OP_SET_PRIO;
      else if (roll < 68) r.opcode = OP_INFO;
      else if (roll < 88) r.opcode = OP_FORK;
      else if (roll < 96) r.opcode = OP_COUNT;
      else                r.opcode = OP_UNDEF;
    end
    roll = $urandom_range(99);
    s = SLOT_W'($urandom_range(SLOTS - 1));
    r.target_pid = $urandom;
    if (roll < 80) begin
      got = 1'b0;
      for (int i = 0; i < 6 && !got; i++) begin
        s = SLOT_W'($urandom_range(SLOTS - 1));
        if (proc_tbl[s].pstate != PS_TERM) begin
          r.target_pid = proc_tbl[s].pid;
          got = 1'b1;
        end
      end
    end else if (roll < 85) r.target_pid = '0;
    else if (roll < 90) r.target_pid = NO_PID;
    else if (roll < 95) r.target_pid = proc_tbl[s].pid + PID_W'(SLOTS);
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [63:0] want,
                           input logic [63:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (pending_results.size() == 0) begin
      n_err++;
      $display("%0t: result with none expected, actual pid %0h status %0d",
               $time, got.pid_out, got.status);
    end else begin
      want = pending_results.pop_front();
      n_checked++;
      case (want.status)
        ST_OK:        n_ok++;
        ST_NOT_FOUND: n_missing++;
        ST_DENIED:    n_denied++;
        default:      n_full++;
      endcase
      cmp_field("status", 64'(want.status), 64'(got.status));
      cmp_field("pid_out", 64'(want.pid_out), 64'(got.pid_out));
      cmp_field("proc_state", 64'(want.proc_state), 64'(got.proc_state));
      cmp_field("priority_out", 64'(want.priority_out), 64'(got.priority_out));
      cmp_field("kernel_out", 64'(want.kernel_out), 64'(got.kernel_out));
      cmp_field("parent_out", 64'(want.parent_out), 64'(got.parent_out));
      cmp_field("mem_bytes", 64'(want.mem_bytes), 64'(got.mem_bytes));
      cmp_field("stack_top", 64'(want.stack_top), 64'(got.stack_top));
      cmp_field("active_count", 64'(want.active_count), 64'(got.active_count));
    end
  endtask

  // Offers one request, with a random gap in front of it, and records the
  // expected result once the transfer happens.
  task automatic push_request(input req_t r, input bit typed, input rsp_t want);
    int unsigned gap_pct;
    rsp_t        pred;
    gap_pct = (mode == MODE_SRC_IDLE) ? 55 : (mode == MODE_BOTH) ? 10 : 0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    pred = process_table_outcome(r);
    pending_results.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result side: checks each transfer and drives ready.
  initial begin : result_side
    int unsigned hold_left;
    int unsigned stall_pct;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_result(rsp_if.data);
      stall_pct = (mode == MODE_SNK_STALL) ? 55 : (mode == MODE_BOTH) ? 10 : 0;
      if (mode == MODE_PRESSURE && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: timeout after %0d cycles", cycles);
    $display("tb: done, errors");
    $finish;
  end

  initial begin : request_side
    int unsigned create_pct;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    clear_table();

    // Reset image, refusals and the first allocation are known by inspection.
    add_step(rq(OP_INFO, 32'd0, 8'd0, 1'b0, PS_CREATED), 1'b1,
             rsp_t'{ST_OK, 32'd0, PS_RUNNING, 8'd255, 1'b1, 32'd0, 15'd0,
                    47'h7FFF_0000_0000, 7'd1});
    add_step(rq(OP_INFO, 32'd1, 8'd0, 1'b0, PS_CREATED), 1'b1,
             rsp_t'{ST_OK, 32'd1, PS_READY, 8'd0, 1'b1, 32'd1, 15'd16384,
                    47'h7FFE_FFFF_8000, 7'd1});
    add_step(rq(OP_COUNT, '1, 8'd255, 1'b1, PS_SPARE), 1'b1,
             rsp_t'{ST_OK, 32'd0, 3'd0, 8'd0, 1'b0, 32'd0, 15'd0, 47'd0, 7'd1});
    add_step(rq(OP_UNDEF, 32'd1, 8'd9, 1'b1, PS_READY), 1'b1,
             rsp_t'{ST_OK, 32'd0, 3'd0, 8'd0, 1'b0, 32'd0, 15'd0, 47'd0, 7'd1});
    add_step(rq(OP_KILL, 32'd0, 8'd0, 1'b0, PS_CREATED), 1'b1,
             rsp_t'{ST_DENIED, '1, 3'd0, 8'd0, 1'b0, 32'd0, 15'd0, 47'd0, 7'd1});
    add_step(rq(OP_KILL, '1, 8'd0, 1'b0, PS_CREATED), 1'b1,
             rsp_t'{ST_NOT_FOUND, '1, 3'd0, 8'd0, 1'b0, 32'd0, 15'd0, 47'd0, 7'd1});
    add_step(rq(OP_CREATE, 32'd0, 8'd255, 1'b1, PS_CREATED), 1'b1,
             rsp_t'{ST_OK, 32'd2, PS_READY, 8'd255, 1'b1, 32'd1, 15'd16384,
                    47'h7FFE_FFFF_0000, 7'd2});
    add_step(rq(OP_SET_PRIO, 32'd5, 8'd1, 1'b0, PS_CREATED), 1'b1,
             rsp_t'{ST_NOT_FOUND, '1, 3'd0, 8'd0, 1'b0, 32'd0, 15'd0, 47'd0, 7'd2});
    // The rest follow from the predictor.
    add_step(rq(OP_CREATE, '1, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_SET_PRIO, 32'd3, 8'hAA, 1'b1, PS_SPARE), 1'b0, '0);
    add_step(rq(OP_SET_STATE, 32'd3, 8'd0, 1'b0, PS_BLOCKED), 1'b0, '0);
    add_step(rq(OP_SET_STATE, 32'd2, 8'd0, 1'b0, PS_SPARE), 1'b0, '0);
    add_step(rq(OP_INFO, 32'd2, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_FORK, 32'd2, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_FORK, 32'd1, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_SET_STATE, 32'd4, 8'd0, 1'b0, PS_TERM), 1'b0, '0);
    add_step(rq(OP_INFO, 32'd4, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_CREATE, 32'd0, 8'h55, 1'b1, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_KILL, 32'd3, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_KILL, 32'd3, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_FORK, 32'd3, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_SET_PRIO, 32'd0, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_INFO, 32'd66, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_SET_STATE, 32'd1, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);
    add_step(rq(OP_COUNT, 32'd0, 8'd0, 1'b0, PS_CREATED), 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < dir_req.size(); k++) push_request(dir_req[k], dir_typed[k], dir_rsp[k]);
    wait_drained();

    // Each phase changes the idling pattern and how hard creates push on the
    // table; the first one is meant to run the table full.
    for (int ph = 0; ph < 5; ph++) begin
      mode = mode_e'(ph);
      case (mode)
        MODE_STEADY:    create_pct = 55;
        MODE_SRC_IDLE:  create_pct = 20;
        MODE_SNK_STALL: create_pct = 45;
        MODE_BOTH:      create_pct = 30;
        default:        create_pct = 40;
      endcase
      for (int n = 0; n < RAND_ITEMS; n++) push_request(random_request(create_pct), 1'b0, '0);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("tb: %0d requests, %0d results checked: %0d ok, %0d not found, %0d denied, %0d full",
             n_sent, n_checked, n_ok, n_missing, n_denied, n_full);
    $display("tb: phases with no idling, sender gaps, receiver stalls, both, long hold-off");
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches, %0d results missing", n_err, pending_results.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
